### rtl/assert_macros.svh
// Assertion macros for the receiver RTL (used by srfr_decoder).
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/srfr_pkg.sv
// Shared constants and types for the SLIP reply frame receiver.
// No dependencies.
package srfr_pkg;

    localparam logic [7:0]  SLIP_END     = 8'hC0;
    localparam logic [7:0]  SLIP_ESC     = 8'hDB;
    localparam logic [7:0]  SLIP_ESC_END = 8'hDC;
    localparam logic [7:0]  SLIP_ESC_ESC = 8'hDD;
    localparam int          CNT_W        = 17;
    localparam logic [CNT_W-1:0] HEADER_LEN = 17'd8;
    localparam logic [CNT_W-1:0] COUNT_MAX  = 17'h1FFFF;
    localparam logic [CNT_W-1:0] MIN_LEN    = 17'd4;
    localparam logic [7:0]  DIR_REPLY    = 8'h01;
    localparam int          OUT_TDATA_W  = 88;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_DIR = 3'd1,
        ST_SHORT   = 3'd2,
        ST_LEN     = 3'd3,
        ST_BAD_ESC = 3'd4
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [15:0] data_index;
        logic [7:0]  command;
        logic [15:0] declared_size;
        logic [31:0] reply_value;
        t_status     frame_status;
    } t_result;

endpackage

### rtl/srfr_in_stage.sv
// Input register for received bytes.
// Depends on srfr_pkg.
module srfr_in_stage
    import srfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = (r_byte == SLIP_END) ? SLIP_END : r_byte;

endmodule

### rtl/srfr_decoder.sv
// Frame state and per-byte decode: delimiter hunt, unescape, header capture.
// Depends on srfr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module srfr_decoder
    import srfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic             r_in_frame, n_in_frame;
    logic             r_esc, n_esc;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_dir, n_dir;
    logic [7:0]       r_cmd, n_cmd;
    logic [15:0]      r_size, n_size;
    logic [31:0]      r_value, n_value;

    logic             take;
    logic [7:0]       take_byte;
    logic [CNT_W-1:0] idx_full;
    logic [15:0]      idx;
    logic [CNT_W-1:0] want_len;
    t_status          verdict;
    logic             in_header;

    assign idx_full  = r_count - HEADER_LEN;
    assign idx       = idx_full[CNT_W-1] ? 16'hFFFF : idx_full[15:0];
    assign want_len  = {1'b0, r_size} + HEADER_LEN;
    assign in_header = (r_count[CNT_W-1:3] == '0);

    always_comb begin
        if (r_count < MIN_LEN) begin
            verdict = ST_SHORT;
        end else if (r_dir != DIR_REPLY) begin
            verdict = ST_BAD_DIR;
        end else if (r_count != want_len) begin
            verdict = ST_LEN;
        end else begin
            verdict = ST_OK;
        end
    end

    always_comb begin
        n_in_frame  = r_in_frame;
        n_esc       = r_esc;
        n_count     = r_count;
        n_dir       = r_dir;
        n_cmd       = r_cmd;
        n_size      = r_size;
        n_value     = r_value;
        take        = 1'b0;
        take_byte   = i_byte;
        o_res_valid = 1'b0;
        o_res.kind          = KIND_DATA;
        o_res.data_byte     = 8'h00;
        o_res.data_index    = 16'h0000;
        o_res.command       = r_cmd;
        o_res.declared_size = r_size;
        o_res.reply_value   = r_value;
        o_res.frame_status  = ST_OK;

        if (i_step) begin
            if (!r_in_frame) begin
                // hunt: drop everything but the opening delimiter
                if (i_byte == SLIP_END) begin
                    n_in_frame = 1'b1;
                    n_esc      = 1'b0;
                    n_count    = '0;
                    n_dir      = 8'h00;
                    n_cmd      = 8'h00;
                    n_size     = 16'h0000;
                    n_value    = 32'h0;
                end
            end else if (i_byte == SLIP_END) begin
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_STATUS;
                o_res.frame_status = verdict;
                n_in_frame         = 1'b0;
                n_esc              = 1'b0;
            end else if (r_esc) begin
                n_esc = 1'b0;
                if (i_byte == SLIP_ESC_END) begin
                    take      = 1'b1;
                    take_byte = SLIP_END;
                end else if (i_byte == SLIP_ESC_ESC) begin
                    take      = 1'b1;
                    take_byte = SLIP_ESC;
                end else begin
                    // abort the frame on a bad escape
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_STATUS;
                    o_res.frame_status = ST_BAD_ESC;
                    n_in_frame         = 1'b0;
                end
            end else if (i_byte == SLIP_ESC) begin
                n_esc = 1'b1;
            end else begin
                take = 1'b1;
            end
        end

        if (take) begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
            if (in_header) begin
                case (r_count[2:0])
                    3'd0:    n_dir          = take_byte;
                    3'd1:    n_cmd          = take_byte;
                    3'd2:    n_size[7:0]    = take_byte;
                    3'd3:    n_size[15:8]   = take_byte;
                    3'd4:    n_value[7:0]   = take_byte;
                    3'd5:    n_value[15:8]  = take_byte;
                    3'd6:    n_value[23:16] = take_byte;
                    3'd7:    n_value[31:24] = take_byte;
                    default: n_dir          = r_dir;
                endcase
            end else begin
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_DATA;
                o_res.data_byte  = take_byte;
                o_res.data_index = idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_count    <= '0;
            r_dir      <= 8'h00;
            r_cmd      <= 8'h00;
            r_size     <= 16'h0000;
            r_value    <= 32'h0;
        end else begin
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_count    <= n_count;
            r_dir      <= n_dir;
            r_cmd      <= n_cmd;
            r_size     <= n_size;
            r_value    <= n_value;
        end
    end

    `ASSERT_NEVER(a_esc_outside_frame, i_clk, i_rst_n, r_esc && !r_in_frame, "escape pending outside a frame")
    `ASSERT_NEVER(a_result_while_hunting, i_clk, i_rst_n, o_res_valid && !r_in_frame, "result while hunting")
    `ASSERT_CLK(a_status_closes_frame, i_clk, i_rst_n, (o_res_valid && o_res.kind == KIND_STATUS) |=> !r_in_frame, "frame still open after status")
    `ASSERT_NEVER(a_payload_in_header, i_clk, i_rst_n, o_res_valid && o_res.kind == KIND_DATA && in_header, "payload beat during header")
    `ASSERT_NEVER(a_ok_bad_dir, i_clk, i_rst_n, o_res_valid && o_res.frame_status == ST_OK && o_res.kind == KIND_STATUS && r_dir != DIR_REPLY, "ok status with wrong direction")

endmodule

### rtl/srfr_out_stage.sv
// Result register on the master side of the receiver.
// Depends on srfr_pkg.
module srfr_out_stage
    import srfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load && o_free) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### rtl/slip_reply_frame_receiver.sv
// SLIP reply frame receiver: takes one raw byte per beat and delivers payload
// bytes with their index and one status beat per closed frame. Depends on
// srfr_pkg, srfr_in_stage, srfr_decoder and srfr_out_stage.
//
// Throughput is one byte per clock cycle while the master side accepts:
// every byte passes through an input register, a combinational decode of
// the frame state, and a result register, and a result becomes valid on the
// master side when the result register loads it. Bytes that yield no result
// (delimiter hunt, escapes, header bytes) are absorbed at the same rate.
// Back-pressure on the master side stalls decode and, after the input
// register fills, the slave side.
module slip_reply_frame_receiver
    import srfr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] data_byte, [23:8] data_index, [31:24] command,
    // [47:32] declared_size, [79:48] reply_value, [82:80] frame_status, rest 0
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser    // kind
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       step;
    logic       dec_valid;
    t_result    dec_res;
    t_result    out_res;

    srfr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_take  (step),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    // advance one byte whenever the result register can take a beat
    assign step = in_valid && out_free;

    srfr_decoder u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_res_valid (dec_valid),
        .o_res       (dec_res)
    );

    srfr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (dec_valid),
        .i_res   (dec_res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {5'b00000, out_res.frame_status, out_res.reply_value,
                           out_res.declared_size, out_res.command,
                           out_res.data_index, out_res.data_byte};

endmodule
